// ===== hw/rtl/edom_pkg.sv =====
// Package with the shared types, constants and helper functions of the echo distance monitor.
package edom_pkg;

   // Field widths of the words on the channels.
   localparam int unsigned ECHO_W  = 16;
   localparam int unsigned DIST_W  = 11;
   localparam int unsigned RUN_W   = 10;
   localparam int unsigned COUNT_W = 2;
   localparam int unsigned INDEX_W = 2;
   localparam int unsigned DATA_W  = 11;

   // Register reset values.
   localparam logic [DIST_W-1:0] OBSTACLE_LIMIT_RESET = 11'd30;
   localparam logic [DIST_W-1:0] SAME_TOLERANCE_RESET = 11'd25;
   localparam logic [RUN_W-1:0]  STUCK_REPEATS_RESET  = 10'd10;

   // The run counter saturates at its all-ones value.
   localparam logic [RUN_W-1:0] RUN_MAX = '1;

   // Samples per median group, as the index of the last slot.
   localparam logic [COUNT_W-1:0] LAST_SLOT = 2'd2;

   // Divide by 58 as a halving and then a divide by 29. With a 15-bit dividend,
   // 18079 / 2^19 is close enough to 1/29 that the floor is always exact.
   localparam int unsigned    DIV_HALF_W = ECHO_W - 1;
   localparam int unsigned    DIV_PROD_W = 2 * DIV_HALF_W;
   localparam int unsigned    DIV_SHIFT  = 19;
   localparam logic [DIV_HALF_W-1:0] DIV_RECIP = 15'd18079;

   // Operation codes of an input word.
   typedef enum logic [0:0] {
      OP_ECHO  = 1'b0,
      OP_CLEAR = 1'b1
   } edom_op_type;

   // Configuration register indexes.
   typedef enum logic [INDEX_W-1:0] {
      CSR_OBSTACLE_LIMIT = 2'd0,
      CSR_SAME_TOLERANCE = 2'd1,
      CSR_STUCK_REPEATS  = 2'd2
   } edom_csr_type;

   // Converts an echo width in microseconds to whole centimetres.
   function automatic logic [DIST_W-1:0] echo_to_cm(input logic [ECHO_W-1:0] echo);
      logic [DIV_PROD_W-1:0] prod;
      prod = DIV_PROD_W'(echo[ECHO_W-1:1]) * DIV_PROD_W'(DIV_RECIP);
      return prod[DIV_SHIFT +: DIST_W];
   endfunction

   // Middle value of three.
   function automatic logic [DIST_W-1:0] median3(input logic [DIST_W-1:0] a,
                                                  input logic [DIST_W-1:0] b,
                                                  input logic [DIST_W-1:0] c);
      logic [DIST_W-1:0] lo;
      logic [DIST_W-1:0] hi;
      logic [DIST_W-1:0] mid;
      lo  = (a < b) ? a : b;
      hi  = (a < b) ? b : a;
      mid = (hi < c) ? hi : c;
      return (lo > mid) ? lo : mid;
   endfunction

endpackage

// ===== hw/rtl/edom_channels.sv =====
// Channel interfaces of the echo distance monitor: request, response and register write.

interface edom_req_if;
   import edom_pkg::*;
   logic              valid;
   logic              ready;
   logic [0:0]        op;
   logic [ECHO_W-1:0] echo_us;
   logic              armed;
   modport source (output valid, output op, output echo_us, output armed, input ready);
   modport sink   (input valid, input op, input echo_us, input armed, output ready);
endinterface

interface edom_rsp_if;
   import edom_pkg::*;
   logic              valid;
   logic              ready;
   logic              distance_valid;
   logic [DIST_W-1:0] distance_out_cm;
   logic              stop_flag;
   logic              stop_motors;
   modport source (output valid, output distance_valid, output distance_out_cm,
                   output stop_flag, output stop_motors, input ready);
   modport sink   (input valid, input distance_valid, input distance_out_cm,
                   input stop_flag, input stop_motors, output ready);
endinterface

interface edom_csr_if;
   import edom_pkg::*;
   logic               valid;
   logic               ready;
   logic [INDEX_W-1:0] index;
   logic [DATA_W-1:0]  wdata;
   modport source (output valid, output index, output wdata, input ready);
   modport sink   (input valid, input index, input wdata, output ready);
endinterface

// ===== hw/rtl/echo_distance_obstacle_monitor_unit.sv =====
// Top level of the echo distance monitor: cm conversion, median of three and stop logic.
//
//   Channel    Direction  Word
//   req_chan   in         op, echo_us, armed
//   rsp_chan   out        distance_valid, distance_out_cm, stop_flag, stop_motors
//   csr_chan   in         index, wdata (register write)
//
// One word is taken per cycle while the response side is not stalled. The divide by 58
// runs on a single 15 x 15 multiplier as a word is captured into the input stage; the word
// is then folded into the filter state and written to the response register.
// Reset is synchronous and clears all control state and the registers to their defaults.
// A stalled response holds both stages; the request side stalls only when both are full.
// Register writes are always taken and take effect in the following cycle.
module echo_distance_obstacle_monitor_unit
   import edom_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   edom_req_if.sink   req_chan,
   edom_rsp_if.source rsp_chan,
   edom_csr_if.sink   csr_chan
);

   // Configuration registers.
   logic [DIST_W-1:0] obstacle_limit_ff;
   logic [DIST_W-1:0] same_tolerance_ff;
   logic [RUN_W-1:0]  stuck_repeats_ff;

   // Input stage.
   logic              s1_valid_ff, s1_valid_in;
   logic [0:0]        s1_op_ff;
   logic [DIST_W-1:0] s1_dist_ff;
   logic              s1_armed_ff;

   // Filter state.
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [DIST_W-1:0]  win0_ff, win0_in;
   logic [DIST_W-1:0]  win1_ff, win1_in;
   logic [DIST_W-1:0]  prev_ff, prev_in;
   logic [RUN_W-1:0]   run_ff, run_in;
   logic               latch_ff, latch_in;

   // Response register.
   logic              rsp_valid_ff;
   logic              rsp_dvalid_ff;
   logic [DIST_W-1:0] rsp_dist_ff;
   logic              rsp_flag_ff;
   logic              rsp_pulse_ff;

   logic              s2_take;
   logic              s2_fire;
   logic              req_fire;
   logic [DIST_W-1:0] median;
   logic [DIST_W-1:0] diff;
   logic              med_valid;
   logic              pulse;

   // Register writes are never stalled; unknown indexes are dropped.
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         obstacle_limit_ff <= OBSTACLE_LIMIT_RESET;
         same_tolerance_ff <= SAME_TOLERANCE_RESET;
         stuck_repeats_ff  <= STUCK_REPEATS_RESET;
      end else if (csr_chan.valid) begin
         unique case (csr_chan.index)
            CSR_OBSTACLE_LIMIT: obstacle_limit_ff <= csr_chan.wdata;
            CSR_SAME_TOLERANCE: same_tolerance_ff <= csr_chan.wdata;
            CSR_STUCK_REPEATS:  stuck_repeats_ff  <= csr_chan.wdata[RUN_W-1:0];
            default: ;
         endcase
      end
   end

   // Handshake: the filter stage moves when the response register is free or leaving.
   assign s2_take        = !rsp_valid_ff || rsp_chan.ready;
   assign s2_fire        = s1_valid_ff && s2_take;
   assign req_chan.ready = !s1_valid_ff || s2_take;
   assign req_fire       = req_chan.valid && req_chan.ready;

   assign s1_valid_in = req_fire || (s1_valid_ff && !s2_take);

   // Input stage: capture the word and convert the echo width to centimetres.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_op_ff    <= req_chan.op;
         s1_dist_ff  <= echo_to_cm(req_chan.echo_us);
         s1_armed_ff <= req_chan.armed;
      end
   end

   // Median of the two stored samples and the newest one, and its change from the last.
   assign median = median3(win0_ff, win1_ff, s1_dist_ff);
   assign diff   = (median >= prev_ff) ? (median - prev_ff) : (prev_ff - median);

   // Filter update for the word leaving the input stage.
   always_comb begin
      count_in  = count_ff;
      win0_in   = win0_ff;
      win1_in   = win1_ff;
      prev_in   = prev_ff;
      run_in    = run_ff;
      latch_in  = latch_ff;
      med_valid = 1'b0;
      pulse     = 1'b0;
      if (s2_fire) begin
         if (s1_op_ff == OP_CLEAR) begin
            latch_in = 1'b0;
         end else if (count_ff >= LAST_SLOT) begin
            count_in  = '0;
            med_valid = 1'b1;
            if (s1_armed_ff && (diff <= same_tolerance_ff)) begin
               run_in = (run_ff == RUN_MAX) ? run_ff : run_ff + 1'b1;
               if (run_in >= stuck_repeats_ff) begin
                  latch_in = 1'b1;
               end
            end else begin
               run_in = '0;
            end
            if (s1_armed_ff && (median <= obstacle_limit_ff)) begin
               latch_in = 1'b1;
               pulse    = 1'b1;
            end
            prev_in = median;
         end else begin
            count_in = count_ff + 1'b1;
            if (count_ff == '0) begin
               win0_in = s1_dist_ff;
            end else begin
               win1_in = s1_dist_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         prev_ff  <= '0;
         run_ff   <= '0;
         latch_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         prev_ff  <= prev_in;
         run_ff   <= run_in;
         latch_ff <= latch_in;
      end
   end

   // The sample window is only read once both entries of the group are written.
   always_ff @(posedge clock) begin
      win0_ff <= win0_in;
      win1_ff <= win1_in;
   end

   // Response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s2_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_fire) begin
         rsp_dvalid_ff <= med_valid;
         rsp_dist_ff   <= med_valid ? median : '0;
         rsp_flag_ff   <= latch_in;
         rsp_pulse_ff  <= pulse;
      end
   end

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.distance_valid  = rsp_dvalid_ff;
   assign rsp_chan.distance_out_cm = rsp_dist_ff;
   assign rsp_chan.stop_flag       = rsp_flag_ff;
   assign rsp_chan.stop_motors     = rsp_pulse_ff;

   // A motor stop always comes with a new distance and a raised flag.
   assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.stop_motors |-> rsp_chan.distance_valid && rsp_chan.stop_flag)
      else $error("stop_motors without distance or stop flag");

   // The group counter never passes the last slot.
   assert property (@(posedge clock) disable iff (reset) count_ff <= LAST_SLOT)
      else $error("sample counter out of range");

   // A clear word leaves the flag low in its response.
   assert property (@(posedge clock) disable iff (reset)
      s2_fire && (s1_op_ff == OP_CLEAR) |=> rsp_chan.valid && !rsp_chan.stop_flag)
      else $error("clear did not drop the stop flag");

   // The third sample of a group gives a distance.
   assert property (@(posedge clock) disable iff (reset)
      s2_fire && (s1_op_ff == OP_ECHO) && (count_ff == LAST_SLOT) |=> rsp_chan.distance_valid)
      else $error("third sample gave no distance");

endmodule
